// ===== rtl/prefix_code_table_decoder_unit_defines.svh =====
// Assertion macros used by the decoder RTL.
`ifndef PREFIX_CODE_TABLE_DECODER_UNIT_DEFINES_SVH
`define PREFIX_CODE_TABLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pcd_pkg.sv =====
package pcd_pkg;

   // Default sizing
   localparam int TABLE_DEPTH_DEF  = 64;
   localparam int MAX_CODE_LEN_DEF = 32;

   // Fixed field widths
   localparam int INDEX_W  = 6;
   localparam int SYMBOL_W = 8;
   localparam int LENGTH_W = 6;
   localparam int CODE_W   = 32;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 7;

   // Function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // Result status codes
   localparam logic STATUS_SYMBOL   = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // Message characters that carry bits
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

   // One code table entry
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [LENGTH_W-1:0] length;
      logic [CODE_W-1:0]   code;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/pcd_entry_ram.sv =====
module pcd_entry_ram
   import pcd_pkg::*;
#(
   parameter int DEPTH  = TABLE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type entry_mem [DEPTH];

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= entry_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/pcd_match.sv =====
module pcd_match
   import pcd_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
   parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  entry_type               entry,
   input  logic [MAX_CODE_LEN-1:0] acc,
   input  logic [LEN_W-1:0]        acc_len,
   output logic                    hit
);

   localparam int CMP_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int CLN_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

   logic [CMP_W-1:0] mask;
   logic [CMP_W-1:0] code_ext;
   logic [CMP_W-1:0] acc_ext;
   logic             len_eq;

   // Only the low acc_len code bits take part; the accumulator has no bits above that
   always_comb begin
      mask     = (CMP_W'(1) << acc_len) - CMP_W'(1);
      code_ext = CMP_W'(entry.code);
      acc_ext  = CMP_W'(acc);
      len_eq   = (CLN_W'(entry.length) == CLN_W'(acc_len)) && (entry.length != '0);
      hit      = len_eq && ((code_ext & mask) == acc_ext);
   end

endmodule

// ===== rtl/prefix_code_table_decoder_unit.sv =====
// Channel  Ports                        Moves
// req      req_valid / req_ready        load or decode item
// rsp      rsp_valid / rsp_ready        decoded symbol or overflow status
// csr      csr_wr_en / csr_wr_data      entry count, written at once
//
// A load item with an index inside the table is written when accepted. A decode
// item with a bit scans up to count = min(entry_count, TABLE_DEPTH) entries: the
// single table read port reads one entry a cycle, pipelined with the compare. A
// hit or an overflow goes through the EMIT state to the output register, which
// holds it while rsp_ready is low. Reset clears the accumulator, the count and
// the handshake; the table is not cleared and holds no data until loaded.
`include "prefix_code_table_decoder_unit_defines.svh"

module prefix_code_table_decoder_unit
   import pcd_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [SYMBOL_W-1:0] req_entry_symbol,
   input  logic [LENGTH_W-1:0] req_entry_length,
   input  logic [CODE_W-1:0]   req_entry_code,
   input  logic [CHAR_W-1:0]   req_in_char,
   input  logic                req_end_of_message,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYMBOL_W-1:0] rsp_symbol,
   output logic                rsp_status,
   // configuration
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int IDX_W  = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;
   localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      entry_count_ff;
   logic [MAX_CODE_LEN-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]        acc_len_ff, acc_len_in;
   logic                    eom_ff, eom_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic                    cmp_last_ff, cmp_last_in;
   logic [SYMBOL_W-1:0]     res_symbol_ff, res_symbol_in;
   logic                    res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    wr_en;
   entry_type               wr_data;
   logic                    rd_en;
   entry_type               rd_data;
   logic                    hit;
   logic                    is_bit;
   logic                    index_ok;
   logic [CNT_W-1:0]        limit_calc;

   // Code table storage
   pcd_entry_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Shared compare unit, one entry per cycle
   pcd_match #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .LEN_W        (LEN_W)
   ) u_match (
      .entry   (rd_data),
      .acc     (acc_ff),
      .acc_len (acc_len_ff),
      .hit     (hit)
   );

   // Decode of the request fields
   always_comb begin
      is_bit   = (req_in_char == CHAR_ZERO) || (req_in_char == CHAR_ONE);
      index_ok = IDX_W'(req_entry_index) < IDX_W'(TABLE_DEPTH);
      if (LIM_W'(entry_count_ff) >= LIM_W'(TABLE_DEPTH)) begin
         limit_calc = CNT_W'(TABLE_DEPTH);
      end else begin
         limit_calc = CNT_W'(entry_count_ff);
      end
      wr_data.symbol = req_entry_symbol;
      wr_data.length = req_entry_length;
      wr_data.code   = req_entry_code;
   end

   // Scan read issue
   always_comb begin
      rd_en = (state_ff == ST_SCAN) && (issue_ff < limit_ff) && !(cmp_valid_ff && hit);
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      acc_len_in    = acc_len_ff;
      eom_in        = eom_ff;
      limit_in      = limit_ff;
      issue_in      = issue_ff;
      res_symbol_in = res_symbol_ff;
      res_status_in = res_status_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmp_valid_in  = rd_en;
      cmp_last_in   = rd_en && (issue_ff == limit_ff - CNT_W'(1));
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  wr_en = index_ok;
               end else if (is_bit) begin
                  if (acc_len_ff >= LEN_W'(MAX_CODE_LEN)) begin
                     // code too long: drop bits, report overflow
                     acc_in        = '0;
                     acc_len_in    = '0;
                     res_symbol_in = '0;
                     res_status_in = STATUS_OVERFLOW;
                     state_in      = ST_EMIT;
                  end else if (limit_calc == '0) begin
                     // nothing to compare against
                     acc_in     = (acc_ff << 1) | MAX_CODE_LEN'(req_in_char[0]);
                     acc_len_in = acc_len_ff + LEN_W'(1);
                     if (req_end_of_message) begin
                        acc_in     = '0;
                        acc_len_in = '0;
                     end
                  end else begin
                     acc_in     = (acc_ff << 1) | MAX_CODE_LEN'(req_in_char[0]);
                     acc_len_in = acc_len_ff + LEN_W'(1);
                     eom_in     = req_end_of_message;
                     limit_in   = limit_calc;
                     issue_in   = '0;
                     state_in   = ST_SCAN;
                  end
               end else if (req_end_of_message) begin
                  acc_in     = '0;
                  acc_len_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff && hit) begin
               res_symbol_in = rd_data.symbol;
               res_status_in = STATUS_SYMBOL;
               acc_in        = '0;
               acc_len_in    = '0;
               state_in      = ST_EMIT;
            end else if (cmp_valid_ff && cmp_last_ff) begin
               if (eom_ff) begin
                  acc_in     = '0;
                  acc_len_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = res_symbol_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         acc_len_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         acc_len_ff   <= acc_len_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_last_ff  <= cmp_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eom_ff        <= eom_in;
      limit_ff      <= limit_in;
      issue_ff      <= issue_in;
      res_symbol_ff <= res_symbol_in;
      res_status_ff <= res_status_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_status = rsp_status_ff;

   // Checks
   `PCD_ASSERT_NOW(a_len_bound, clock, reset, 1'b1,
      acc_len_ff <= LEN_W'(MAX_CODE_LEN), "accumulated length above maximum")
   `PCD_ASSERT_NOW(a_issue_bound, clock, reset, state_ff == ST_SCAN,
      issue_ff <= limit_ff, "scan ran past the entry limit")
   `PCD_ASSERT_NOW(a_emit_cleared, clock, reset, state_ff == ST_EMIT,
      acc_len_ff == '0, "accumulator not cleared before emitting a result")
   `PCD_ASSERT_NEXT(a_hit_emits, clock, reset,
      state_ff == ST_SCAN && cmp_valid_ff && hit,
      state_ff == ST_EMIT && res_status_ff == STATUS_SYMBOL, "hit did not lead to a result")

endmodule

// ===== bench/tb_prefix_code_table_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_prefix_code_table_decoder_unit;
   import pcd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned QUIET_CYCLES = TABLE_DEPTH_DEF + 16;
   localparam int unsigned PHASE_ITEMS  = 80;
   localparam int unsigned PHASES       = 8;

   // One request item as driven on the req_ ports
   typedef struct {
      logic                func;
      logic [INDEX_W-1:0]  index;
      logic [SYMBOL_W-1:0] symbol;
      logic [LENGTH_W-1:0] length;
      logic [CODE_W-1:0]   code;
      logic [CHAR_W-1:0]   in_char;
      logic                eom;
   } decoder_item_type;

   // One response item
   typedef struct {
      logic [SYMBOL_W-1:0] symbol;
      logic                status;
   } decode_result_type;

   // Tracks the code table and bit accumulator, queues expected symbols
   class decode_scoreboard;
      logic [SYMBOL_W-1:0] slot_symbol [TABLE_DEPTH_DEF];
      logic [LENGTH_W-1:0] slot_length [TABLE_DEPTH_DEF];
      logic [CODE_W-1:0]   slot_code   [TABLE_DEPTH_DEF];
      logic [CODE_W-1:0]   bit_window;
      int unsigned         bit_count;
      int unsigned         entry_count;
      decode_result_type   awaited [$];
      int unsigned         errors;
      int unsigned         symbols_seen;
      int unsigned         overflows_seen;

      function new();
         bit_window     = '0;
         bit_count      = 0;
         entry_count    = 0;
         errors         = 0;
         symbols_seen   = 0;
         overflows_seen = 0;
      endfunction

      // Accepted request: update table or accumulator, queue any result
      function void note_request(decoder_item_type it);
         int unsigned       scan;
         int unsigned       j;
         logic [63:0]       keep;
         bit                hit;
         decode_result_type res;
         if (it.func == FUNC_LOAD) begin
            slot_symbol[it.index] = it.symbol;
            slot_length[it.index] = it.length;
            slot_code[it.index]   = it.code;
            return;
         end
         hit = 0;
         if (it.in_char == CHAR_ZERO || it.in_char == CHAR_ONE) begin
            if (bit_count >= MAX_CODE_LEN_DEF) begin
               // accumulator full: drop everything, report overflow
               res.symbol = '0;
               res.status = STATUS_OVERFLOW;
               awaited.push_back(res);
               bit_window = '0;
               bit_count  = 0;
            end else begin
               bit_window = {bit_window[CODE_W-2:0], it.in_char[0]};
               bit_count++;
               scan = (entry_count < TABLE_DEPTH_DEF) ? entry_count : TABLE_DEPTH_DEF;
               // lowest index with equal length and code wins
               for (j = 0; j < scan && !hit; j++) begin
                  if (slot_length[j] != 0 && slot_length[j] == bit_count) begin
                     keep = (64'd1 << slot_length[j]) - 64'd1;
                     if (({32'd0, slot_code[j]} & keep) == {32'd0, bit_window}) begin
                        hit        = 1;
                        res.symbol = slot_symbol[j];
                        res.status = STATUS_SYMBOL;
                        awaited.push_back(res);
                        bit_window = '0;
                        bit_count  = 0;
                     end
                  end
               end
            end
         end
         if (it.eom) begin
            bit_window = '0;
            bit_count  = 0;
         end
      endfunction

      // Accepted response: compare with the oldest expectation
      function void check_response(logic [SYMBOL_W-1:0] symbol, logic status);
         decode_result_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: symbol %0h status %0b", symbol, status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (symbol !== want.symbol) begin
            $error("symbol: expected %0h, actual %0h", want.symbol, symbol);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, status);
            errors++;
         end
         if (want.status == STATUS_OVERFLOW) overflows_seen++;
         else symbols_seen++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_func;
   logic [INDEX_W-1:0]  req_entry_index;
   logic [SYMBOL_W-1:0] req_entry_symbol;
   logic [LENGTH_W-1:0] req_entry_length;
   logic [CODE_W-1:0]   req_entry_code;
   logic [CHAR_W-1:0]   req_in_char;
   logic                req_end_of_message;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SYMBOL_W-1:0] rsp_symbol;
   logic                rsp_status;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   decode_scoreboard board;
   int unsigned      cycle_count = 0;
   int unsigned      items_sent = 0;
   int unsigned      loads_sent = 0;
   int unsigned      decodes_sent = 0;
   int unsigned      settings_used = 0;
   int unsigned      hold_left = 0;
   bit               hold_done = 0;
   int unsigned      results_now;

   int unsigned phase_counts [PHASES] = '{0, 3, 64, 127, 1, 16, 64, 40};
   bit          phase_long   [PHASES] = '{0, 0, 1, 0, 0, 0, 1, 1};

   prefix_code_table_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_symbol   (req_entry_symbol),
      .req_entry_length   (req_entry_length),
      .req_entry_code     (req_entry_code),
      .req_in_char        (req_in_char),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_symbol         (rsp_symbol),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 2 ns clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[prefix_code_table_decoder_unit] ERROR");
      $finish;
   end

   // Response side: random stalls, one long hold-off, one calm stretch
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         results_now = board.symbols_seen + board.overflows_seen;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && results_now >= 10) begin
            hold_done = 1;
            hold_left = 600;
            rsp_ready <= 1'b0;
         end else if (results_now >= 30 && results_now < 60) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 34);
         end
      end
   end

   // Result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_symbol, rsp_status);
   end

   // Offer one item; valid stays up until accepted
   task automatic send_item(input decoder_item_type it);
      while (!(items_sent >= 400 && items_sent < 550) && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= it.func;
      req_entry_index    <= it.index;
      req_entry_symbol   <= it.symbol;
      req_entry_length   <= it.length;
      req_entry_code     <= it.code;
      req_in_char        <= it.in_char;
      req_end_of_message <= it.eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(it);
      items_sent++;
      if (it.func == FUNC_LOAD) loads_sent++;
      else decodes_sent++;
   endtask

   task automatic load_slot(input int unsigned idx, input logic [SYMBOL_W-1:0] sym,
                            input int unsigned len, input logic [CODE_W-1:0] code,
                            input bit eom);
      decoder_item_type it;
      it.func    = FUNC_LOAD;
      it.index   = INDEX_W'(idx);
      it.symbol  = sym;
      it.length  = LENGTH_W'(len);
      it.code    = code;
      it.in_char = CHAR_W'($urandom);
      it.eom     = eom;
      send_item(it);
   endtask

   // Decode item; table fields carry junk
   task automatic send_char(input logic [CHAR_W-1:0] ch, input bit eom);
      decoder_item_type it;
      it.func    = FUNC_DECODE;
      it.index   = INDEX_W'($urandom);
      it.symbol  = SYMBOL_W'($urandom);
      it.length  = LENGTH_W'($urandom);
      it.code    = $urandom;
      it.in_char = ch;
      it.eom     = eom;
      send_item(it);
   endtask

   // Mostly usable lengths, some zero, some too long, some at the maximum
   function automatic int unsigned pick_length(input bit long_codes);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return 0;
      if (r < 12) return $urandom_range(MAX_CODE_LEN_DEF + 1, 63);
      if (r < 18) return MAX_CODE_LEN_DEF;
      return long_codes ? $urandom_range(20, MAX_CODE_LEN_DEF - 1) : $urandom_range(1, 6);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_noise();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom); while (c == CHAR_ZERO || c == CHAR_ONE);
      return c;
   endfunction

   task automatic load_random_slot(input int unsigned idx, input bit long_codes);
      load_slot(idx, SYMBOL_W'($urandom), pick_length(long_codes), $urandom,
                1'($urandom_range(0, 1)));
   endtask

   // Send a stored code MSB first, starting from an empty accumulator
   task automatic send_codeword(input int unsigned slot);
      int                len;
      int                b;
      logic [CODE_W-1:0] code;
      len  = int'(board.slot_length[slot]);
      code = board.slot_code[slot];
      if (board.bit_count != 0) send_char(pick_noise(), 1'b1);
      for (b = len - 1; b >= 0; b--) begin
         if ($urandom_range(0, 99) < 5) send_char(pick_noise(), 1'b0);
         send_char(code[b] ? CHAR_ONE : CHAR_ZERO,
                   (b == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 49) == 0));
      end
   endtask

   task automatic send_random_bits(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++)
         send_char($urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO, $urandom_range(0, 29) == 0);
   endtask

   // Drain everything, then give a silent decode scan time to finish
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(input int unsigned value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.entry_count = value;
      settings_used++;
   endtask

   // Stimulus
   initial begin
      int unsigned p;
      int unsigned j;
      int unsigned lim;
      int unsigned start;
      int unsigned r;
      int unsigned slot;
      int unsigned tries;
      bit          found;
      board = new();
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_func           <= FUNC_LOAD;
      req_entry_index    <= '0;
      req_entry_symbol   <= '0;
      req_entry_length   <= '0;
      req_entry_code     <= '0;
      req_in_char        <= '0;
      req_end_of_message <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table: zero length, shadowed duplicate, junk above length,
      // lengths past the maximum, top slot outside the scan
      load_slot(0, 8'hEE, 0, 32'h0000_0000, 1'b0);
      load_slot(1, 8'h00, 2, 32'hABCD_0002, 1'b0);
      load_slot(2, 8'h55, 2, 32'h0000_0002, 1'b0);
      load_slot(3, 8'hFF, 1, 32'hFFFF_FFFE, 1'b0);
      load_slot(4, 8'h12, 33, 32'h0000_0000, 1'b0);
      load_slot(5, 8'h80, 32, 32'hFFFF_FFFF, 1'b0);
      load_slot(6, 8'h7F, 63, 32'hFFFF_FFFF, 1'b0);
      load_slot(63, 8'hA5, 5, 32'h0000_0015, 1'b0);
      set_entry_count(7);
      send_char(CHAR_ZERO, 1'b0);
      send_char(CHAR_ONE, 1'b0);
      send_char(8'h78, 1'b0);
      send_char(8'hB0, 1'b0);
      send_char(CHAR_ZERO, 1'b0);
      send_char(CHAR_ONE, 1'b1);
      send_char(CHAR_ZERO, 1'b1);
      // end-of-message on a load must not clear the pending bit
      send_char(CHAR_ONE, 1'b0);
      load_slot(62, 8'h3C, 4, 32'h0000_0009, 1'b1);
      send_char(CHAR_ZERO, 1'b0);
      // noise character with end-of-message still clears
      send_char(CHAR_ONE, 1'b0);
      send_char(8'hFF, 1'b1);
      send_char(CHAR_ZERO, 1'b0);

      // Random phases, one entry count each
      for (p = 0; p < PHASES; p++) begin
         lim = (phase_counts[p] < TABLE_DEPTH_DEF) ? phase_counts[p] : TABLE_DEPTH_DEF;
         for (j = 0; j < lim; j++) load_random_slot(j, phase_long[p]);
         set_entry_count(phase_counts[p]);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               found = 0;
               slot  = 0;
               for (tries = 0; tries < 8 && !found && lim > 0; tries++) begin
                  slot = $urandom_range(0, lim - 1);
                  if (board.slot_length[slot] >= 1 && board.slot_length[slot] <= MAX_CODE_LEN_DEF)
                     found = 1;
               end
               if (found) send_codeword(slot);
               else if (lim == 0) send_random_bits($urandom_range(30, 40));
               else send_random_bits($urandom_range(1, 8));
            end else if (r < 78) begin
               load_random_slot($urandom_range(0, TABLE_DEPTH_DEF - 1), phase_long[p]);
            end else if (r < 86) begin
               send_char(pick_noise(), $urandom_range(0, 1));
            end else begin
               send_random_bits($urandom_range(1, 40));
            end
         end
      end

      wait_quiet();
      $display("Covered %0d load and %0d decode items over %0d entry-count settings;",
               loads_sent, decodes_sent, settings_used);
      $display("checked %0d decoded symbols and %0d overflow results in order.",
               board.symbols_seen, board.overflows_seen);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("[prefix_code_table_decoder_unit] OK");
      end else begin
         $display("[prefix_code_table_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== prefix_code_table_decoder_unit.f =====
+incdir+rtl
rtl/pcd_pkg.sv
rtl/pcd_entry_ram.sv
rtl/pcd_match.sv
rtl/prefix_code_table_decoder_unit.sv
bench/tb_prefix_code_table_decoder_unit.sv
